// ----- sv/sehd_pkg.sv -----
// shared types, constants and helper functions for the stx/etx hex crc deframer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package sehd_pkg;

  // framing bytes
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;

  // store index of the etx byte must reach stx + addr + four hex digits
  localparam int ETX_MIN_IDX = 1 + 4 + 1;
  // first payload byte sits after stx and address
  localparam int PAYLOAD_IDX = 2;

  // result status codes
  localparam logic [1:0] ST_PAYLOAD  = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_CRCERR   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // payload count width, sized for the largest store of 64 bytes
  localparam int CNT_W = 7;

  // command queue between front and back
  localparam int Q_AW    = 2;
  localparam int Q_DEPTH = 1 << Q_AW;

  typedef struct packed {
    logic       channel;
    logic [7:0] rx_byte;
    logic       chunk_end;
  } in_beat_t;

  typedef struct packed {
    logic       out_channel;
    logic [1:0] status;
    logic [7:0] payload_byte;
    logic       last;
  } out_beat_t;

  // one command from front to back: a single status beat or a payload burst
  typedef struct packed {
    logic             burst;
    logic             channel;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } cmd_t;

  // bit 4 flags a non-hex character, bits 3:0 hold the digit value
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  // modbus crc-16, one byte, reflected poly 0xa001
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ 16'hA001;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sehd_front.sv -----
// front part: per-channel framing state, running crc, hex check, store writes
// uses sehd_pkg; pushes commands into sehd_queue and writes the store in sehd_back
`timescale 1ns / 1ps
`default_nettype none

module sehd_front import sehd_pkg::*; #(
  parameter int BUFFER_DEPTH = 64,
  parameter int CHANNELS     = 2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_beat_t in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output cmd_t          q_cmd,
  input  wire logic     burst_done,
  output logic          burst_pend,
  output logic          wr_en,
  output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1) + $clog2(BUFFER_DEPTH)-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NSLOT  = 1 << CH_W;
  localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
  localparam int ADDR_W = $clog2(BUFFER_DEPTH);

  // per-channel state
  logic              rcv_r  [NSLOT];
  logic              disc_r [NSLOT];
  logic [FILL_W-1:0] fill_r [NSLOT];
  logic [15:0]       crc_r  [NSLOT];
  logic [7:0]        win_r  [NSLOT][4];
  logic              burst_pend_r;

  logic              accept, ch_ok, is_stx, is_etx, live, rcv_cur, ovf, store;
  logic [CH_W-1:0]   ch_idx;
  logic [FILL_W-1:0] f_cur, n_pay;
  logic [4:0]        h0, h1, h2, h3;
  logic              crc_ok;

  assign in_stall   = burst_pend_r || q_full;
  assign burst_pend = burst_pend_r;
  assign accept     = in_valid && !in_stall;

  // classify the beat
  assign ch_idx  = CH_W'(in_data.channel);
  assign ch_ok   = 32'(in_data.channel) < CHANNELS;
  assign is_stx  = in_data.rx_byte == BYTE_STX;
  assign is_etx  = in_data.rx_byte == BYTE_ETX;
  assign live    = accept && ch_ok && !disc_r[ch_idx];
  assign rcv_cur = is_stx || rcv_r[ch_idx];
  assign f_cur   = is_stx ? '0 : fill_r[ch_idx];
  assign ovf     = live && rcv_cur && (f_cur >= FILL_W'(BUFFER_DEPTH));
  assign store   = live && rcv_cur && !ovf;

  // store write
  assign wr_en   = store;
  assign wr_addr = {ch_idx, f_cur[ADDR_W-1:0]};
  assign wr_data = in_data.rx_byte;

  // crc check against the four hex digits held in the window
  assign h0     = hex_val(win_r[ch_idx][0]);
  assign h1     = hex_val(win_r[ch_idx][1]);
  assign h2     = hex_val(win_r[ch_idx][2]);
  assign h3     = hex_val(win_r[ch_idx][3]);
  assign crc_ok = (f_cur >= FILL_W'(ETX_MIN_IDX)) && !(h0[4] || h1[4] || h2[4] || h3[4])
                  && ({h0[3:0], h1[3:0], h2[3:0], h3[3:0]} == crc_r[ch_idx]);
  assign n_pay  = f_cur - FILL_W'(ETX_MIN_IDX);

  // command to the back part
  always_comb begin
    q_push        = ovf || (store && is_etx);
    q_cmd.burst   = 1'b0;
    q_cmd.channel = in_data.channel;
    q_cmd.status  = ST_OVERFLOW;
    q_cmd.count   = CNT_W'(n_pay);
    if (!ovf) begin
      if (!crc_ok) begin
        q_cmd.status = ST_CRCERR;
      end else if (n_pay == '0) begin
        q_cmd.status = ST_EMPTY;
      end else begin
        q_cmd.status = ST_PAYLOAD;
        q_cmd.burst  = 1'b1;
      end
    end
  end

  // per-channel state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        rcv_r[i]  <= 1'b0;
        disc_r[i] <= 1'b0;
        fill_r[i] <= '0;
      end
    end else if (accept && ch_ok) begin
      if (disc_r[ch_idx]) begin
        if (in_data.chunk_end) begin
          disc_r[ch_idx] <= 1'b0;
        end
      end else if (ovf) begin
        rcv_r[ch_idx] <= 1'b0;
        fill_r[ch_idx] <= f_cur;
        if (!in_data.chunk_end) begin
          disc_r[ch_idx] <= 1'b1;
        end
      end else if (store) begin
        rcv_r[ch_idx]  <= !is_etx;
        fill_r[ch_idx] <= f_cur + 1'b1;
      end
    end
  end

  // running crc over bytes leaving the four byte window
  always_ff @(posedge clk) begin
    if (store && !is_etx) begin
      win_r[ch_idx][0] <= win_r[ch_idx][1];
      win_r[ch_idx][1] <= win_r[ch_idx][2];
      win_r[ch_idx][2] <= win_r[ch_idx][3];
      win_r[ch_idx][3] <= in_data.rx_byte;
      if (f_cur == '0) begin
        crc_r[ch_idx] <= 16'hFFFF;
      end else if (f_cur >= FILL_W'(5)) begin
        crc_r[ch_idx] <= crc16_byte(crc_r[ch_idx], win_r[ch_idx][0]);
      end
    end
  end

  // hold input while a payload burst reads the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_pend_r <= 1'b0;
    end else if (q_push && q_cmd.burst) begin
      burst_pend_r <= 1'b1;
    end else if (burst_done) begin
      burst_pend_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sehd_queue.sv -----
// short command queue between the front and back parts
// uses sehd_pkg for the command type
`timescale 1ns / 1ps
`default_nettype none

module sehd_queue import sehd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output cmd_t      head
);

  cmd_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign full  = cnt_r == (Q_AW + 1)'(Q_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = slot_r[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sehd_back.sv -----
// back part: frame store memory, payload burst reader and result register
// uses sehd_pkg; takes commands from sehd_queue and store writes from sehd_front
`timescale 1ns / 1ps
`default_nettype none

module sehd_back import sehd_pkg::*; #(
  parameter int BUFFER_DEPTH = 64,
  parameter int CHANNELS     = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_en,
  input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1) + $clog2(BUFFER_DEPTH)-1:0] wr_addr,
  input  wire logic [7:0] wr_data,
  input  wire logic       q_empty,
  input  wire cmd_t       q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_beat_t       out_data,
  output logic            burst_done
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int MEM_AW = CH_W + ADDR_W;

  logic [7:0]        mem [1 << MEM_AW];
  logic              active_r, rd_valid_r, rd_valid_nxt, rd_last_r;
  logic              ch_r;
  logic [MEM_AW-1:0] addr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [7:0]        rd_data_r;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_data_r;

  logic out_free, idle, take_stat, take_burst, rd_move, rd_issue;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // handshake between queue head, read slot and result register
  assign out_free   = !out_valid_r || !out_stall;
  assign idle       = !active_r && !rd_valid_r;
  assign take_stat  = idle && !q_empty && !q_head.burst && out_free;
  assign take_burst = idle && !q_empty && q_head.burst;
  assign q_pop      = take_stat || take_burst;
  assign rd_move    = rd_valid_r && out_free;
  assign rd_issue   = active_r && (!rd_valid_r || out_free);
  assign burst_done = rd_move && rd_last_r;

  assign rd_valid_nxt  = rd_issue || (rd_valid_r && !rd_move);
  assign out_valid_nxt = rd_move || take_stat || (out_valid_r && out_stall);

  // frame store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_issue) begin
      rd_data_r <= mem[addr_r];
    end
  end

  // burst sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_valid_nxt;
      if (take_burst) begin
        active_r <= 1'b1;
      end else if (rd_issue && cnt_r == CNT_W'(1)) begin
        active_r <= 1'b0;
      end
    end
  end

  // burst address and count
  always_ff @(posedge clk) begin
    if (take_burst) begin
      addr_r <= {CH_W'(q_head.channel), ADDR_W'(PAYLOAD_IDX)};
      cnt_r  <= q_head.count;
      ch_r   <= q_head.channel;
    end else if (rd_issue) begin
      addr_r    <= addr_r + 1'b1;
      cnt_r     <= cnt_r - 1'b1;
      rd_last_r <= cnt_r == CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_move) begin
      out_data_r.out_channel  <= ch_r;
      out_data_r.status       <= ST_PAYLOAD;
      out_data_r.payload_byte <= rd_data_r;
      out_data_r.last         <= rd_last_r;
    end else if (take_stat) begin
      out_data_r.out_channel  <= q_head.channel;
      out_data_r.status       <= q_head.status;
      out_data_r.payload_byte <= 8'h00;
      out_data_r.last         <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/stx_etx_hex_crc_deframer.sv -----
// stx/etx deframer with ascii hex crc-16: a byte is accepted each cycle while no payload
// burst is pending and the command queue has room; a status result is queued, then registered
// in the result register; a payload burst is queued, starts the burst sequencer and gives one
// byte a cycle from the store read port while out_stall is low; queued commands add delay
// input stalls from a good payload frame's etx until its last byte is in the result register
// synchronous active-low reset clears framing state, queue and result valid; store is not cleared
`timescale 1ns / 1ps
`default_nettype none

module stx_etx_hex_crc_deframer import sehd_pkg::*; #(
  parameter int BUFFER_DEPTH = 64,
  parameter int CHANNELS     = 2
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_data
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_AW = CH_W + $clog2(BUFFER_DEPTH);

  logic              q_push, q_pop, q_full, q_empty;
  cmd_t              q_cmd, q_head;
  logic              burst_done, burst_pend;
  logic              wr_en;
  logic [MEM_AW-1:0] wr_addr;
  logic [7:0]        wr_data;

  // front: framing and crc
  sehd_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .CHANNELS    (CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .burst_done(burst_done),
    .burst_pend(burst_pend),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // command queue
  sehd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (q_head)
  );

  // back: store and result generation
  sehd_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .CHANNELS    (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .burst_done(burst_done)
  );

  // no command pushed into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("command pushed into full queue");

  // a burst only finishes after the front marked it pending
  a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
    burst_done |-> burst_pend)
    else $error("burst finished with none pending");

  // no beat accepted while the store is being read out
  a_hold_in: assert property (@(posedge clk) disable iff (!rst_n) burst_pend |-> in_stall)
    else $error("input accepted during payload burst");

  // status results are always the final result of their beat
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_PAYLOAD)
      |-> (out_data.last && out_data.payload_byte == 8'h00))
    else $error("status result without last or with payload");

endmodule

`default_nettype wire
